// ===== sv/s2a_pkg.sv =====
// ----------------------------------------------------------------------------
// s2a_pkg
// Shared types, scancode constants and keymap tables for the set-1 scancode
// to ASCII decoder with its character FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package s2a_pkg;

  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
  localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;

  localparam logic OP_SCANCODE = 1'b0;
  localparam logic OP_READ     = 1'b1;

  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_PUSH = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam int CHAR_W = 7;
  localparam int FILL_W = 7;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CHAR_W-1:0] ch;
  } cmd_t;

  function automatic logic [CHAR_W-1:0] plain_char(input logic [6:0] idx);
    logic [CHAR_W-1:0] c;
    unique case (idx)
      7'd1:  c = 7'h1B;
      7'd2:  c = 7'h31;
      7'd3:  c = 7'h32;
      7'd4:  c = 7'h33;
      7'd5:  c = 7'h34;
      7'd6:  c = 7'h35;
      7'd7:  c = 7'h36;
      7'd8:  c = 7'h37;
      7'd9:  c = 7'h38;
      7'd10: c = 7'h39;
      7'd11: c = 7'h30;
      7'd12: c = 7'h2D;
      7'd13: c = 7'h3D;
      7'd14: c = 7'h08;
      7'd15: c = 7'h09;
      7'd16: c = 7'h71;
      7'd17: c = 7'h77;
      7'd18: c = 7'h65;
      7'd19: c = 7'h72;
      7'd20: c = 7'h74;
      7'd21: c = 7'h79;
      7'd22: c = 7'h75;
      7'd23: c = 7'h69;
      7'd24: c = 7'h6F;
      7'd25: c = 7'h70;
      7'd26: c = 7'h5B;
      7'd27: c = 7'h5D;
      7'd28: c = 7'h0A;
      7'd30: c = 7'h61;
      7'd31: c = 7'h73;
      7'd32: c = 7'h64;
      7'd33: c = 7'h66;
      7'd34: c = 7'h67;
      7'd35: c = 7'h68;
      7'd36: c = 7'h6A;
      7'd37: c = 7'h6B;
      7'd38: c = 7'h6C;
      7'd39: c = 7'h3B;
      7'd40: c = 7'h27;
      7'd41: c = 7'h60;
      7'd43: c = 7'h5C;
      7'd44: c = 7'h7A;
      7'd45: c = 7'h78;
      7'd46: c = 7'h63;
      7'd47: c = 7'h76;
      7'd48: c = 7'h62;
      7'd49: c = 7'h6E;
      7'd50: c = 7'h6D;
      7'd51: c = 7'h2C;
      7'd52: c = 7'h2E;
      7'd53: c = 7'h2F;
      7'd55: c = 7'h2A;
      7'd57: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] shifted_char(input logic [6:0] idx);
    logic [CHAR_W-1:0] c;
    unique case (idx)
      7'd1:  c = 7'h1B;
      7'd2:  c = 7'h21;
      7'd3:  c = 7'h40;
      7'd4:  c = 7'h23;
      7'd5:  c = 7'h24;
      7'd6:  c = 7'h25;
      7'd7:  c = 7'h5E;
      7'd8:  c = 7'h26;
      7'd9:  c = 7'h2A;
      7'd10: c = 7'h28;
      7'd11: c = 7'h29;
      7'd12: c = 7'h5F;
      7'd13: c = 7'h2B;
      7'd14: c = 7'h08;
      7'd15: c = 7'h09;
      7'd16: c = 7'h51;
      7'd17: c = 7'h57;
      7'd18: c = 7'h45;
      7'd19: c = 7'h52;
      7'd20: c = 7'h54;
      7'd21: c = 7'h59;
      7'd22: c = 7'h55;
      7'd23: c = 7'h49;
      7'd24: c = 7'h4F;
      7'd25: c = 7'h50;
      7'd26: c = 7'h7B;
      7'd27: c = 7'h7D;
      7'd28: c = 7'h0A;
      7'd30: c = 7'h41;
      7'd31: c = 7'h53;
      7'd32: c = 7'h44;
      7'd33: c = 7'h46;
      7'd34: c = 7'h47;
      7'd35: c = 7'h48;
      7'd36: c = 7'h4A;
      7'd37: c = 7'h4B;
      7'd38: c = 7'h4C;
      7'd39: c = 7'h3A;
      7'd40: c = 7'h22;
      7'd41: c = 7'h7E;
      7'd43: c = 7'h7C;
      7'd44: c = 7'h5A;
      7'd45: c = 7'h58;
      7'd46: c = 7'h43;
      7'd47: c = 7'h56;
      7'd48: c = 7'h42;
      7'd49: c = 7'h4E;
      7'd50: c = 7'h4D;
      7'd51: c = 7'h3C;
      7'd52: c = 7'h3E;
      7'd53: c = 7'h3F;
      7'd55: c = 7'h2A;
      7'd57: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/s2a_front.sv =====
// ----------------------------------------------------------------------------
// s2a_front
// Accepts input transactions, tracks shift and caps lock, and turns each
// one into a command (read, push character, or nothing) for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module s2a_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          in_ready,
  input  wire logic          op,
  input  wire logic [7:0]    scancode,
  output s2a_pkg::cmd_t      cmd
);

  logic shift_held;
  logic shift_held_next;
  logic caps_lock;
  logic caps_lock_next;
  logic [s2a_pkg::CHAR_W-1:0] plain;
  logic [s2a_pkg::CHAR_W-1:0] shifted;
  logic letter_key;
  logic use_shift;
  logic [s2a_pkg::CHAR_W-1:0] ch;

  always_comb begin
    plain      = s2a_pkg::plain_char(scancode[6:0]);
    shifted    = s2a_pkg::shifted_char(scancode[6:0]);
    letter_key = (plain >= 7'h61) && (plain <= 7'h7A);
    use_shift  = shift_held ^ (caps_lock & letter_key);
    ch         = use_shift ? shifted : plain;
  end

  always_comb begin
    cmd             = '{kind: s2a_pkg::CMD_NONE, ch: ch};
    shift_held_next = shift_held;
    caps_lock_next  = caps_lock;
    if (op == s2a_pkg::OP_READ) begin
      cmd.kind = s2a_pkg::CMD_READ;
    end else begin
      unique case (scancode) inside
        s2a_pkg::SC_LSHIFT_MAKE, s2a_pkg::SC_RSHIFT_MAKE: begin
          shift_held_next = 1'b1;
        end
        s2a_pkg::SC_LSHIFT_BREAK, s2a_pkg::SC_RSHIFT_BREAK: begin
          shift_held_next = 1'b0;
        end
        s2a_pkg::SC_CAPS_MAKE: begin
          caps_lock_next = ~caps_lock;
        end
        default: begin
          if (!scancode[7] && (ch != '0)) begin
            cmd.kind = s2a_pkg::CMD_PUSH;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held <= 1'b0;
      caps_lock  <= 1'b0;
    end else if (in_valid && in_ready) begin
      shift_held <= shift_held_next;
      caps_lock  <= caps_lock_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/s2a_queue.sv =====
// ----------------------------------------------------------------------------
// s2a_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module s2a_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire s2a_pkg::cmd_t push_cmd,
  output logic               not_full,
  input  wire logic          pop,
  output logic               not_empty,
  output s2a_pkg::cmd_t      head
);

  s2a_pkg::cmd_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign not_full  = (count != 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/s2a_back.sv =====
// ----------------------------------------------------------------------------
// s2a_back
// Executes commands against the character ring FIFO and holds the result
// in an output register until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module s2a_back #(
  parameter int FIFO_DEPTH = 128
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cmd_valid,
  input  wire s2a_pkg::cmd_t              cmd,
  output logic                            cmd_pop,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            char_valid,
  output logic [s2a_pkg::CHAR_W-1:0]      char_code,
  output logic                            dropped,
  output logic [s2a_pkg::FILL_W-1:0]      fill_level
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int XW = (PW > s2a_pkg::FILL_W) ? PW : s2a_pkg::FILL_W;
  localparam logic [PW-1:0] LAST  = PW'(FIFO_DEPTH - 1);

  logic [s2a_pkg::CHAR_W-1:0] mem [FIFO_DEPTH];
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] count;
  logic [PW-1:0] count_next;
  logic [s2a_pkg::CHAR_W-1:0] rd_data;
  logic fire;
  logic empty;
  logic full;
  logic do_write;
  logic do_read;
  logic hit;
  logic drop_next;
  logic [XW-1:0] count_wide;

  assign fire    = cmd_valid && (!out_valid || out_ready);
  assign cmd_pop = fire;
  assign empty   = (count == '0);
  assign full    = (count == LAST);

  always_comb begin
    do_write   = 1'b0;
    do_read    = 1'b0;
    drop_next  = 1'b0;
    count_next = count;
    case (cmd.kind)
      s2a_pkg::CMD_PUSH: begin
        if (full) begin
          drop_next = 1'b1;
        end else begin
          do_write   = 1'b1;
          count_next = count + 1'b1;
        end
      end
      s2a_pkg::CMD_READ: begin
        if (!empty) begin
          do_read    = 1'b1;
          count_next = count - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fire && do_write) begin
      mem[wr_ptr] <= cmd.ch;
    end
    if (fire && do_read) begin
      rd_data <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      count     <= '0;
      out_valid <= 1'b0;
      hit       <= 1'b0;
      dropped   <= 1'b0;
    end else begin
      if (fire) begin
        count   <= count_next;
        hit     <= do_read;
        dropped <= drop_next;
        if (do_write) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
        if (do_read)  rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign count_wide = XW'(count);
  assign fill_level = count_wide[s2a_pkg::FILL_W-1:0];
  assign char_valid = hit;
  assign char_code  = hit ? rd_data : '0;

endmodule

`default_nettype wire

// ===== sv/scancode_to_ascii_fifo.sv =====
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo
// Set-1 keyboard scancode decoder feeding a character ring FIFO.
// ----------------------------------------------------------------------------
// Input stream: s_axis_tuser selects the transaction kind (0 = scancode byte
// in s_axis_tdata, 1 = host read of one character). Every input transaction
// yields exactly one output transaction on m_axis, in order.
// Output: char_valid, char_code, dropped and the FIFO fill level after the
// transaction. A read of an empty FIFO returns char_valid 0; a character
// decoded while the FIFO holds FIFO_DEPTH-1 entries is dropped and flagged.
// Path: a transaction accepted on s_axis is written into the command queue,
// then moved by the back end into the output register that drives m_axis.
// Throughput: one transaction per cycle while the receiver is ready, limited
// by the single FIFO write or read the back end does per cycle.
// A stalled receiver holds the output register; the two-entry command queue
// keeps s_axis_tready high until it fills, after which the input stalls.
// Synchronous reset clears shift, caps lock, the FIFO pointers and all
// valid flags; FIFO storage is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module scancode_to_ascii_fifo #(
  parameter int FIFO_DEPTH = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] scancode
  input  wire logic [0:0]  s_axis_tuser,   // [0] op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // [0] char_valid, [7:1] char_code,
                                           // [8] dropped, [15:9] fill_level
);

  s2a_pkg::cmd_t front_cmd;
  s2a_pkg::cmd_t queue_head;
  logic q_not_full;
  logic q_not_empty;
  logic q_pop;
  logic char_valid;
  logic [s2a_pkg::CHAR_W-1:0] char_code;
  logic dropped;
  logic [s2a_pkg::FILL_W-1:0] fill_level;

  assign s_axis_tready = q_not_full;

  s2a_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (q_not_full),
    .op       (s_axis_tuser[0]),
    .scancode (s_axis_tdata),
    .cmd      (front_cmd)
  );

  s2a_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_axis_tvalid && q_not_full),
    .push_cmd  (front_cmd),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (queue_head)
  );

  s2a_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (q_not_empty),
    .cmd        (queue_head),
    .cmd_pop    (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .char_valid (char_valid),
    .char_code  (char_code),
    .dropped    (dropped),
    .fill_level (fill_level)
  );

  assign m_axis_tdata = {fill_level, dropped, char_code, char_valid};

endmodule

`default_nettype wire

// ===== sv/s2a_checker.sv =====
// ----------------------------------------------------------------------------
// s2a_checker
// Port-level checks for the scancode decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module s2a_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  // stalled result must stay presented
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output transaction withdrawn while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // a popped character is never zero, a miss carries no character
  a_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[7:1] != 7'd0)))
    else $error("char_code does not match char_valid");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[8]))
    else $error("read reported as dropped");

endmodule

bind scancode_to_ascii_fifo s2a_checker u_s2a_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== tb/sv/scancode_to_ascii_fifo_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo_test
// Self-checking bench for the set-1 scancode decoder and its character FIFO.
// A directed table covers shift, caps lock, break codes, keys with no
// character and empty reads. Random typing, read bursts, noise and
// fill-past-full bursts follow. Every output transaction is checked against
// a local keymap and ring buffer. Both stream sides idle at random.
// ----------------------------------------------------------------------------

module scancode_to_ascii_fifo_test;

  localparam int          RING_DEPTH   = 128;
  localparam int          RANDOM_ITEMS = 1800;
  localparam int          LONG_HOLD    = 60;
  localparam int          TAIL_CYCLES  = 8;
  localparam longint      WATCHDOG_NS  = 5_000_000;
  localparam logic [7:0]  BREAK_BIT    = 8'h80;
  localparam logic [6:0]  LAST_KEY     = 7'd57;

  typedef struct packed {
    logic [6:0] fill;
    logic       dropped;
    logic [6:0] code;
    logic       valid;
  } kbd_out_t;

  typedef struct {
    logic       op;
    logic [7:0] sc;
    bit         known;
    kbd_out_t   want;
  } stim_row_t;

  // keymaps by scancode; a blank stands for "no character" except at the space bar
  string plain_keys   = " \0331234567890-=\010\011qwertyuiop[]\012 asdfghjkl;'` \\zxcvbnm,./ *  ";
  string shifted_keys = " \033!@#$%^&*()_+\010\011QWERTYUIOP{}\012 ASDFGHJKL:\"~ |ZXCVBNM<>? *  ";

  logic       clk;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic [0:0] s_axis_tuser = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  logic       shift_on;
  logic       caps_on;
  logic [6:0] char_ring [RING_DEPTH];
  int         ring_rd;
  int         ring_wr;

  kbd_out_t   pending_outputs [$];
  kbd_out_t   want;
  kbd_out_t   got;
  int         errors = 0;
  int         work_items = 0;
  bit         sender_idle = 1'b1;
  bit         sink_idle = 1'b1;
  bit         long_hold_req = 1'b0;

  scancode_to_ascii_fifo #(.FIFO_DEPTH(RING_DEPTH)) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [6:0] key_char(logic [6:0] idx, logic upper);
    byte ch;
    if (idx > LAST_KEY) return '0;
    ch = upper ? shifted_keys.getc(idx) : plain_keys.getc(idx);
    if (ch == " " && idx != LAST_KEY) return '0;
    return ch[6:0];
  endfunction

  function automatic int ring_fill();
    return (ring_wr + RING_DEPTH - ring_rd) % RING_DEPTH;
  endfunction

  function automatic kbd_out_t decode_keystroke(logic op, logic [7:0] sc);
    kbd_out_t   r;
    logic [6:0] base;
    logic [6:0] ch;
    logic       upper;
    int         wr_next;
    r = '0;
    if (op == s2a_pkg::OP_READ) begin
      if (ring_rd != ring_wr) begin
        r.valid = 1'b1;
        r.code  = char_ring[ring_rd];
        ring_rd = (ring_rd + 1) % RING_DEPTH;
      end
    end else if (sc == s2a_pkg::SC_LSHIFT_MAKE || sc == s2a_pkg::SC_RSHIFT_MAKE) begin
      shift_on = 1'b1;
    end else if (sc == s2a_pkg::SC_LSHIFT_BREAK || sc == s2a_pkg::SC_RSHIFT_BREAK) begin
      shift_on = 1'b0;
    end else if (sc == s2a_pkg::SC_CAPS_MAKE) begin
      caps_on = !caps_on;
    end else if ((sc & BREAK_BIT) == 8'h00) begin
      base  = key_char(sc[6:0], 1'b0);
      // caps lock only flips the case of letters
      upper = shift_on ^ (caps_on && base >= 7'h61 && base <= 7'h7A);
      ch    = key_char(sc[6:0], upper);
      if (ch != 7'd0) begin
        wr_next = (ring_wr + 1) % RING_DEPTH;
        if (wr_next != ring_rd) begin
          char_ring[ring_wr] = ch;
          ring_wr = wr_next;
        end else begin
          r.dropped = 1'b1;
        end
      end
    end
    r.fill = 7'(ring_fill());
    return r;
  endfunction

  function automatic stim_row_t stim_row(logic op, logic [7:0] sc, bit known, logic [6:0] fill);
    stim_row_t r;
    r.op        = op;
    r.sc        = sc;
    r.known     = known;
    r.want      = '0;
    r.want.fill = fill;
    return r;
  endfunction

  function automatic logic [7:0] random_key();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(1, 57));
    return 8'($urandom_range(0, 127));
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic send_item(logic op, logic [7:0] sc, bit known, kbd_out_t known_out);
    kbd_out_t r;
    int       gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= sc;
    do @(posedge clk); while (!s_axis_tready);
    r = decode_keystroke(op, sc);
    pending_outputs.push_back(known ? known_out : r);
    work_items++;
    @(negedge clk);
    gap = 0;
    if (sender_idle) begin
      gap = $urandom_range(0, 99);
      gap = (gap < 60) ? 0 : (gap < 90) ? $urandom_range(1, 3) : $urandom_range(6, 25);
    end
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_outputs.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_outputs.size() == 0) begin
        $error("output transaction with nothing pending: %h", m_axis_tdata);
        errors++;
      end else begin
        want = pending_outputs.pop_front();
        if (got.valid !== want.valid) begin
          $error("char_valid: expected %0d, got %0d", want.valid, got.valid);
          errors++;
        end
        if (got.code !== want.code) begin
          $error("char_code: expected %h, got %h", want.code, got.code);
          errors++;
        end
        if (got.dropped !== want.dropped) begin
          $error("dropped: expected %0d, got %0d", want.dropped, got.dropped);
          errors++;
        end
        if (got.fill !== want.fill) begin
          $error("fill_level: expected %0d, got %0d", want.fill, got.fill);
          errors++;
        end
      end
    end
  end

  initial begin : sink
    int hold_left;
    hold_left = 0;
    @(negedge clk);
    forever begin
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        hold_left = LONG_HOLD - 1;
      end else if (!sink_idle || $urandom_range(0, 99) < 70) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        hold_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(6, 20);
      end
      @(negedge clk);
    end
  end

  initial begin
    #(WATCHDOG_NS);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    stim_row_t  directed_rows [$];
    int         kind;
    bit         first_phase;
    bit         with_shift;
    logic [7:0] key;

    shift_on = 1'b0;
    caps_on  = 1'b0;
    ring_rd  = 0;
    ring_wr  = 0;

    directed_rows = '{
      stim_row(s2a_pkg::OP_READ,     8'hFF,                    1'b1, 7'd0),  // empty read
      stim_row(s2a_pkg::OP_SCANCODE, 8'h00,                    1'b1, 7'd0),  // no character
      stim_row(s2a_pkg::OP_SCANCODE, 8'h1E,                    1'b0, 7'd0),
      stim_row(s2a_pkg::OP_SCANCODE, s2a_pkg::SC_LSHIFT_MAKE,  1'b1, 7'd1),
      stim_row(s2a_pkg::OP_SCANCODE, 8'h1E,                    1'b0, 7'd0),
      stim_row(s2a_pkg::OP_SCANCODE, 8'h02,                    1'b0, 7'd0),
      stim_row(s2a_pkg::OP_SCANCODE, s2a_pkg::SC_LSHIFT_BREAK, 1'b1, 7'd3),
      stim_row(s2a_pkg::OP_SCANCODE, s2a_pkg::SC_CAPS_MAKE,    1'b1, 7'd3),
      stim_row(s2a_pkg::OP_SCANCODE, 8'h10,                    1'b0, 7'd0),
      stim_row(s2a_pkg::OP_SCANCODE, 8'h02,                    1'b0, 7'd0),  // caps, non-letter
      stim_row(s2a_pkg::OP_SCANCODE, s2a_pkg::SC_RSHIFT_MAKE,  1'b1, 7'd5),
      stim_row(s2a_pkg::OP_SCANCODE, 8'h10,                    1'b0, 7'd0),  // caps and shift
      stim_row(s2a_pkg::OP_SCANCODE, 8'h0C,                    1'b0, 7'd0),
      stim_row(s2a_pkg::OP_SCANCODE, s2a_pkg::SC_RSHIFT_BREAK, 1'b1, 7'd7),
      stim_row(s2a_pkg::OP_SCANCODE, 8'hBA,                    1'b1, 7'd7),  // caps break ignored
      stim_row(s2a_pkg::OP_SCANCODE, BREAK_BIT,                1'b1, 7'd7),
      stim_row(s2a_pkg::OP_SCANCODE, 8'hFF,                    1'b1, 7'd7),
      stim_row(s2a_pkg::OP_SCANCODE, 8'h7F,                    1'b1, 7'd7),
      stim_row(s2a_pkg::OP_SCANCODE, 8'h39,                    1'b0, 7'd0),
      stim_row(s2a_pkg::OP_SCANCODE, 8'h01,                    1'b0, 7'd0),
      stim_row(s2a_pkg::OP_SCANCODE, s2a_pkg::SC_CAPS_MAKE,    1'b1, 7'd9),
      stim_row(s2a_pkg::OP_READ,     8'h00,                    1'b0, 7'd0),
      stim_row(s2a_pkg::OP_READ,     8'hFF,                    1'b0, 7'd0),
      stim_row(s2a_pkg::OP_READ,     8'h55,                    1'b0, 7'd0),
      stim_row(s2a_pkg::OP_READ,     8'hAA,                    1'b0, 7'd0)
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].sc, directed_rows[i].known,
                directed_rows[i].want);

    work_items  = 0;
    first_phase = 1'b1;
    while (work_items < RANDOM_ITEMS) begin
      sender_idle = $urandom_range(0, 9) < 7;
      sink_idle   = $urandom_range(0, 9) < 7;
      kind = first_phase ? 80 : $urandom_range(0, 99);
      if (kind < 45) begin
        repeat ($urandom_range(1, 12)) begin
          key        = random_key();
          with_shift = $urandom_range(0, 4) == 0;
          if ($urandom_range(0, 19) == 0)
            send_item(s2a_pkg::OP_SCANCODE, s2a_pkg::SC_CAPS_MAKE, 1'b0, '0);
          if (with_shift)
            send_item(s2a_pkg::OP_SCANCODE,
                      $urandom_range(0, 1) ? s2a_pkg::SC_LSHIFT_MAKE : s2a_pkg::SC_RSHIFT_MAKE,
                      1'b0, '0);
          send_item(s2a_pkg::OP_SCANCODE, key, 1'b0, '0);
          if ($urandom_range(0, 1))
            send_item(s2a_pkg::OP_SCANCODE, key | BREAK_BIT, 1'b0, '0);
          if (with_shift)
            send_item(s2a_pkg::OP_SCANCODE,
                      $urandom_range(0, 1) ? s2a_pkg::SC_LSHIFT_BREAK : s2a_pkg::SC_RSHIFT_BREAK,
                      1'b0, '0);
          if ($urandom_range(0, 9) < 4)
            send_item(s2a_pkg::OP_READ, 8'($urandom_range(0, 255)), 1'b0, '0);
        end
      end else if (kind < 60) begin
        repeat ($urandom_range(1, 20))
          send_item(s2a_pkg::OP_READ, 8'($urandom_range(0, 255)), 1'b0, '0);
      end else if (kind < 75) begin
        repeat ($urandom_range(1, 15))
          send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, '0);
      end else if (kind < 85) begin
        // push past full, the receiver holding off on the first pass and at random after
        sender_idle = 1'b0;
        if (first_phase || $urandom_range(0, 1))
          long_hold_req = 1'b1;
        repeat ($urandom_range(130, 150))
          send_item(s2a_pkg::OP_SCANCODE, 8'($urandom_range(16, 25)), 1'b0, '0);
      end else begin
        while (ring_fill() != 0)
          send_item(s2a_pkg::OP_READ, 8'($urandom_range(0, 255)), 1'b0, '0);
        repeat ($urandom_range(1, 3))
          send_item(s2a_pkg::OP_READ, 8'($urandom_range(0, 255)), 1'b0, '0);
      end
      if (first_phase || $urandom_range(0, 9) == 0)
        pause_until_drained();
      first_phase = 1'b0;
    end

    pause_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
sv/s2a_pkg.sv
sv/s2a_front.sv
sv/s2a_queue.sv
sv/s2a_back.sv
sv/scancode_to_ascii_fifo.sv
sv/s2a_checker.sv
tb/sv/scancode_to_ascii_fifo_test.sv
